[rtl/core/pac_pkg.sv]
// shared types and constants for the polygon area, centroid and inertia block
// no dependencies
package pac_pkg;

	localparam int WORD_W = 64;
	localparam int WIDE_W = 128;
	localparam int REM_W  = 67;
	localparam int STEP_W = 7;

	typedef struct packed {
		logic              start;
		logic              root;
		logic [STEP_W-1:0] top;
	} iter_req_t;

endpackage

[rtl/core/pac_mul.sv]
// 64 x 64 unsigned multiplier built from one 32 x 32 multiplier over four passes
// depends on pac_pkg
module pac_mul (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [pac_pkg::WORD_W-1:0] a,
	input  logic [pac_pkg::WORD_W-1:0] b,
	output logic                       done,
	output logic [pac_pkg::WIDE_W-1:0] prod
);
	import pac_pkg::*;

	logic [WORD_W-1:0] a_q, b_q;
	logic [2:0]        cnt_q;
	logic              busy_q, done_q;
	logic [1:0]        sh_q;
	logic [63:0]       p_s1;
	logic [WIDE_W-1:0] prod_q, p_ext;
	logic [31:0]       a_part, b_part;

	assign a_part = cnt_q[1] ? a_q[63:32] : a_q[31:0];
	assign b_part = cnt_q[0] ? b_q[63:32] : b_q[31:0];

	always_comb begin
		case (sh_q)
			2'd0:    p_ext = {64'b0, p_s1};
			2'd3:    p_ext = {p_s1, 64'b0};
			default: p_ext = {32'b0, p_s1, 32'b0};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 3'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 3'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == 3'd4) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q    <= a;
			b_q    <= b;
			prod_q <= '0;
		end else if (busy_q) begin
			if (cnt_q != 3'd4) begin
				p_s1 <= a_part * b_part;
				sh_q <= cnt_q[1:0];
			end
			if (cnt_q != 3'd0)
				prod_q <= prod_q + p_ext;
		end
	end

	assign done = done_q;
	assign prod = prod_q;

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("multiplier done without a pass in flight");
	a_idle_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("multiplier still busy at done");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> cnt_q <= 3'd4)
		else $error("multiplier pass count out of range");

endmodule

[rtl/core/pac_iter.sv]
// shared compare and subtract unit: bitwise square root and restoring division
// depends on pac_pkg
module pac_iter (
	input  logic                       clk,
	input  logic                       arst_n,
	input  pac_pkg::iter_req_t         req,
	input  logic [pac_pkg::WIDE_W-1:0] n,
	input  logic [pac_pkg::WORD_W-1:0] d,
	output logic                       done,
	output logic [pac_pkg::WORD_W-1:0] res
);
	import pac_pkg::*;

	logic [STEP_W-1:0] i_q;
	logic              busy_q, done_q, root_q, over_q;
	logic [REM_W-1:0]  rem_q, a_in, b_in, diff;
	logic [WORD_W-1:0] q_q;
	logic              take;

	always_comb begin
		if (root_q) begin
			a_in = {rem_q[64:0], n[{i_q[5:0], 1'b1}], n[{i_q[5:0], 1'b0}]};
			b_in = {1'b0, q_q, 2'b01};
		end else begin
			a_in = {2'b00, rem_q[63:0], n[i_q]};
			b_in = {3'b000, d};
		end
		take = a_in >= b_in;
		diff = a_in - b_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				i_q    <= req.top;
			end else if (busy_q) begin
				i_q <= i_q - 1'b1;
				if (i_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			root_q <= req.root;
			rem_q  <= '0;
			q_q    <= '0;
			over_q <= 1'b0;
		end else if (busy_q) begin
			rem_q <= take ? diff : a_in;
			q_q   <= {q_q[WORD_W-2:0], take};
			if (take && i_q[6] && !root_q)
				over_q <= 1'b1;
		end
	end

	assign done = done_q;
	assign res  = (over_q && !root_q) ? '1 : q_q;

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !req.start)
		else $error("iteration restarted while busy");
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q) && $past(i_q) == '0)
		else $error("iteration done early");
	a_root_no_over: assert property (@(posedge clk) disable iff (!arst_n)
		root_q && busy_q |-> !over_q || !root_q)
		else $error("square root flagged overflow");

endmodule

[rtl/core/polygon_area_centroid_inertia.sv]
// polygon area, centroid and in-plane second moments over a vertex stream
// depends on pac_pkg, pac_mul, pac_iter
// One vertex is taken per transfer; the polygon is fanned into triangles from its first
// vertex. The first two vertices of a polygon are only registered. Every later vertex
// runs a micro-sequence of 30 products on the shared 64 x 64 multiplier (the divisions
// by 3 and 12 done as reciprocal products) and a 64-step square root on the shared
// compare/subtract unit, with vertex_ready low meanwhile. A vertex marked last adds a
// check state and, unless the polygon is degenerate, six divisions of 64 + FRACTION_BITS
// steps before the result is loaded into the output register; that load waits only
// while an earlier result is still unaccepted. A degenerate polygon (fewer than three
// vertices or zero area) reports all zeros with degenerate set. A waiting result does
// not block the next vertex.
module polygon_area_centroid_inertia #(
	parameter int FRACTION_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               vertex_valid,
	output logic               vertex_ready,
	input  logic signed [31:0] vertex_x,
	input  logic signed [31:0] vertex_y,
	input  logic signed [31:0] vertex_z,
	input  logic               last_vertex,
	output logic               result_valid,
	input  logic               result_ready,
	output logic [47:0]        polygon_area,
	output logic signed [31:0] centroid_x,
	output logic signed [31:0] centroid_y,
	output logic signed [31:0] centroid_z,
	output logic [46:0]        moment_xx,
	output logic signed [47:0] moment_xy,
	output logic [46:0]        moment_yy,
	output logic               degenerate
);
	import pac_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_ISSUE = 3'd1;
	localparam logic [2:0] ST_WAIT  = 3'd2;
	localparam logic [2:0] ST_CHECK = 3'd3;
	localparam logic [2:0] ST_OUT   = 3'd4;

	localparam logic [1:0] K_MUL  = 2'd0;
	localparam logic [1:0] K_ROOT = 2'd1;
	localparam logic [1:0] K_DIV  = 2'd2;

	localparam logic [5:0] PC_TRI_LAST = 6'd30;
	localparam logic [5:0] PC_FIN_FIRST = 6'd31;
	localparam logic [5:0] PC_FIN_LAST = 6'd36;

	localparam logic [STEP_W-1:0] TOP_WORD = STEP_W'(63);
	localparam logic [STEP_W-1:0] TOP_FIN  = STEP_W'(63 + FRACTION_BITS);
	localparam logic [63:0] M47 = 64'h0000_7FFF_FFFF_FFFF;
	localparam logic [63:0] M48 = 64'h0000_FFFF_FFFF_FFFF;
	localparam logic [63:0] S31 = 64'h0000_0000_7FFF_FFFF;
	// ceil(2^65 / 3): x / 3 is the product >> 65, x / 12 the product >> 67
	localparam logic [63:0] RECIP3 = 64'hAAAA_AAAA_AAAA_AAAB;

	function automatic logic [63:0] sat_shr(input logic [127:0] v);
		logic [127:0] t;
		t = v >> FRACTION_BITS;
		return (|t[127:64]) ? '1 : t[63:0];
	endfunction

	function automatic logic [127:0] abs128(input logic [127:0] v);
		return v[127] ? (~v + 128'd1) : v;
	endfunction

	function automatic logic [63:0] mag34(input logic [33:0] v);
		logic [33:0] m;
		m = v[33] ? (~v + 34'd1) : v;
		return {30'b0, m};
	endfunction

	function automatic logic [63:0] mag64(input logic [63:0] v);
		return v[63] ? (~v + 64'd1) : v;
	endfunction

	function automatic logic [63:0] to_s64(input logic neg, input logic [63:0] m);
		if (!neg)
			return m[63] ? 64'h7FFF_FFFF_FFFF_FFFF : m;
		return m[63] ? 64'h8000_0000_0000_0000 : (~m + 64'd1);
	endfunction

	function automatic logic [63:0] sadd(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63])
			return s[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
		return s[63:0];
	endfunction

	function automatic logic [63:0] uadd(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[64] ? '1 : s[63:0];
	endfunction

	function automatic logic [33:0] ext(input logic [31:0] v);
		return {{2{v[31]}}, v};
	endfunction

	logic [2:0]         state_q;
	logic [5:0]         pc_q;
	logic [1:0]         seen_q;
	logic               last_q, deg_q, ov_q;
	logic [31:0]        ax_q, ay_q, az_q, px_q, py_q, pz_q, cx_q, cy_q, cz_q;
	logic [63:0]        area_q, wx_q, wy_q, wz_q, mxx_q, myy_q, mxy_q;
	logic [127:0]       acc_q, acc_nx;
	logic [63:0]        ma_q, mb_q, mc_q, s_q, tmp_q, jxx_q, jyy_q, jxy_q, cen_q;
	logic               nxy_q;
	logic [47:0]        area_r, rxy_q;
	logic [31:0]        rcx_q, rcy_q, rcz_q;
	logic [46:0]        rxx_q, ryy_q;

	logic [33:0]        ux, uy, uz, vx, vy, vz, x12, x13, x23, y12, y13, y23, sx, sy, sz;
	logic [33:0]        sa, sb;
	logic               signed_op, sub_op, clr_op;
	logic [1:0]         kind;
	logic [63:0]        mul_a, mul_b, fin_mag, s_new, q, quo3, quo12;
	logic               mul_neg, mul_start, mul_done, iter_done, unit_done;
	logic [127:0]       prod, iter_n;
	logic [63:0]        iter_d, iter_res;
	iter_req_t          iter_req;
	logic               in_xfer, out_xfer, out_free;

	assign ux  = ext(px_q) - ext(ax_q);
	assign uy  = ext(py_q) - ext(ay_q);
	assign uz  = ext(pz_q) - ext(az_q);
	assign vx  = ext(cx_q) - ext(ax_q);
	assign vy  = ext(cy_q) - ext(ay_q);
	assign vz  = ext(cz_q) - ext(az_q);
	assign x12 = ext(ax_q) + ext(px_q);
	assign x13 = ext(ax_q) + ext(cx_q);
	assign x23 = ext(px_q) + ext(cx_q);
	assign y12 = ext(ay_q) + ext(py_q);
	assign y13 = ext(ay_q) + ext(cy_q);
	assign y23 = ext(py_q) + ext(cy_q);
	assign sx  = x12 + ext(cx_q);
	assign sy  = y12 + ext(cy_q);
	assign sz  = ext(az_q) + ext(pz_q) + ext(cz_q);

	// operand selection for each step of the micro-sequence
	always_comb begin
		kind      = K_MUL;
		signed_op = 1'b1;
		sub_op    = 1'b0;
		clr_op    = 1'b0;
		sa        = '0;
		sb        = '0;
		mul_a     = '0;
		mul_b     = '0;
		iter_n    = '0;
		iter_d    = '0;
		fin_mag   = '0;
		case (pc_q)
			6'd0:  begin sa = uy; sb = vz; clr_op = 1'b1; end
			6'd1:  begin sa = uz; sb = vy; sub_op = 1'b1; end
			6'd2:  begin sa = uz; sb = vx; clr_op = 1'b1; end
			6'd3:  begin sa = ux; sb = vz; sub_op = 1'b1; end
			6'd4:  begin sa = ux; sb = vy; clr_op = 1'b1; end
			6'd5:  begin sa = uy; sb = vx; sub_op = 1'b1; end
			6'd6:  begin signed_op = 1'b0; mul_a = ma_q; mul_b = ma_q; clr_op = 1'b1; end
			6'd7:  begin signed_op = 1'b0; mul_a = mb_q; mul_b = mb_q; end
			6'd8:  begin signed_op = 1'b0; mul_a = mc_q; mul_b = mc_q; end
			6'd9:  begin kind = K_ROOT; iter_n = acc_q; end
			6'd10: begin sa = x12; sb = y12; clr_op = 1'b1; end
			6'd11: begin sa = x13; sb = y13; end
			6'd12: begin sa = x23; sb = y23; end
			6'd14: begin sa = x12; sb = x12; clr_op = 1'b1; end
			6'd15: begin sa = x13; sb = x13; end
			6'd16: begin sa = x23; sb = x23; end
			6'd18: begin sa = y12; sb = y12; clr_op = 1'b1; end
			6'd19: begin sa = y13; sb = y13; end
			6'd20: begin sa = y23; sb = y23; end
			6'd13, 6'd17, 6'd21: begin
				signed_op = 1'b0; mul_a = tmp_q; mul_b = RECIP3; clr_op = 1'b1;
			end
			6'd22: begin signed_op = 1'b0; mul_a = mag34(sx); mul_b = RECIP3; clr_op = 1'b1; end
			6'd24: begin signed_op = 1'b0; mul_a = mag34(sy); mul_b = RECIP3; clr_op = 1'b1; end
			6'd26: begin signed_op = 1'b0; mul_a = mag34(sz); mul_b = RECIP3; clr_op = 1'b1; end
			6'd23, 6'd25, 6'd27: begin
				signed_op = 1'b0; mul_a = s_q; mul_b = cen_q; clr_op = 1'b1;
			end
			6'd28: begin signed_op = 1'b0; mul_a = s_q; mul_b = jxx_q; clr_op = 1'b1; end
			6'd29: begin signed_op = 1'b0; mul_a = s_q; mul_b = jyy_q; clr_op = 1'b1; end
			6'd30: begin signed_op = 1'b0; mul_a = s_q; mul_b = jxy_q; clr_op = 1'b1; end
			6'd31: begin kind = K_DIV; fin_mag = mag64(wx_q); end
			6'd32: begin kind = K_DIV; fin_mag = mag64(wy_q); end
			6'd33: begin kind = K_DIV; fin_mag = mag64(wz_q); end
			6'd34: begin kind = K_DIV; fin_mag = mxx_q; end
			6'd35: begin kind = K_DIV; fin_mag = myy_q; end
			6'd36: begin kind = K_DIV; fin_mag = mag64(mxy_q); end
			default: kind = K_MUL;
		endcase
		if (signed_op) begin
			mul_a = mag34(sa);
			mul_b = mag34(sb);
		end
		if (pc_q >= PC_FIN_FIRST) begin
			iter_n = {64'b0, fin_mag} << FRACTION_BITS;
			iter_d = area_q;
		end
	end

	assign mul_neg = (signed_op && (sa[33] ^ sb[33])) ^ sub_op;
	assign acc_nx  = clr_op ? (mul_neg ? (~prod + 128'd1) : prod)
	               : (mul_neg ? (acc_q - prod) : (acc_q + prod));

	assign mul_start      = (state_q == ST_ISSUE) && (kind == K_MUL);
	assign iter_req.start = (state_q == ST_ISSUE) && (kind != K_MUL);
	assign iter_req.root  = (kind == K_ROOT);
	assign iter_req.top   = (kind == K_ROOT) ? TOP_WORD : TOP_FIN;

	pac_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (prod)
	);

	pac_iter u_iter (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (iter_req),
		.n      (iter_n),
		.d      (iter_d),
		.done   (iter_done),
		.res    (iter_res)
	);

	assign unit_done    = (kind == K_MUL) ? mul_done : iter_done;
	assign s_new        = {1'b0, iter_res[63:1]};
	assign q            = iter_res;
	assign quo3         = {1'b0, prod[127:65]};
	assign quo12        = {3'b0, prod[127:67]};
	assign vertex_ready = (state_q == ST_IDLE);
	assign in_xfer      = vertex_valid && vertex_ready;
	assign out_xfer     = ov_q && result_ready;
	assign out_free     = !ov_q || result_ready;
	assign area_r       = (area_q > M48) ? M48[47:0] : area_q[47:0];

	// control and polygon state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pc_q    <= '0;
			seen_q  <= '0;
			last_q  <= 1'b0;
			deg_q   <= 1'b0;
			ov_q    <= 1'b0;
			ax_q    <= '0;
			ay_q    <= '0;
			az_q    <= '0;
			px_q    <= '0;
			py_q    <= '0;
			pz_q    <= '0;
			area_q  <= '0;
			wx_q    <= '0;
			wy_q    <= '0;
			wz_q    <= '0;
			mxx_q   <= '0;
			myy_q   <= '0;
			mxy_q   <= '0;
		end else begin
			if (out_xfer && state_q != ST_OUT)
				ov_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						last_q <= last_vertex;
						if (seen_q == 2'd0) begin
							ax_q   <= vertex_x;
							ay_q   <= vertex_y;
							az_q   <= vertex_z;
							px_q   <= vertex_x;
							py_q   <= vertex_y;
							pz_q   <= vertex_z;
							seen_q <= 2'd1;
							if (last_vertex)
								state_q <= ST_CHECK;
						end else if (seen_q == 2'd1) begin
							px_q   <= vertex_x;
							py_q   <= vertex_y;
							pz_q   <= vertex_z;
							seen_q <= 2'd2;
							if (last_vertex)
								state_q <= ST_CHECK;
						end else begin
							pc_q    <= '0;
							state_q <= ST_ISSUE;
						end
					end
				end
				ST_ISSUE: state_q <= ST_WAIT;
				ST_WAIT: begin
					if (unit_done) begin
						case (pc_q)
							6'd9:  area_q <= uadd(area_q, s_new);
							6'd23: wx_q <= sadd(wx_q, to_s64(sx[33], sat_shr(acc_nx)));
							6'd25: wy_q <= sadd(wy_q, to_s64(sy[33], sat_shr(acc_nx)));
							6'd27: wz_q <= sadd(wz_q, to_s64(sz[33], sat_shr(acc_nx)));
							6'd28: mxx_q <= uadd(mxx_q, sat_shr(acc_nx));
							6'd29: myy_q <= uadd(myy_q, sat_shr(acc_nx));
							6'd30: mxy_q <= sadd(mxy_q, to_s64(nxy_q, sat_shr(acc_nx)));
							default: ;
						endcase
						if (pc_q == PC_TRI_LAST) begin
							px_q    <= cx_q;
							py_q    <= cy_q;
							pz_q    <= cz_q;
							seen_q  <= 2'd3;
							state_q <= last_q ? ST_CHECK : ST_IDLE;
						end else if (pc_q == PC_FIN_LAST) begin
							state_q <= ST_OUT;
						end else begin
							pc_q    <= pc_q + 6'd1;
							state_q <= ST_ISSUE;
						end
					end
				end
				ST_CHECK: begin
					if (seen_q != 2'd3 || area_q == '0) begin
						deg_q   <= 1'b1;
						state_q <= ST_OUT;
					end else begin
						deg_q   <= 1'b0;
						pc_q    <= PC_FIN_FIRST;
						state_q <= ST_ISSUE;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						ov_q    <= 1'b1;
						seen_q  <= '0;
						ax_q    <= '0;
						ay_q    <= '0;
						az_q    <= '0;
						px_q    <= '0;
						py_q    <= '0;
						pz_q    <= '0;
						area_q  <= '0;
						wx_q    <= '0;
						wy_q    <= '0;
						wz_q    <= '0;
						mxx_q   <= '0;
						myy_q   <= '0;
						mxy_q   <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			cx_q <= vertex_x;
			cy_q <= vertex_y;
			cz_q <= vertex_z;
		end
		if (state_q == ST_WAIT && unit_done) begin
			if (kind == K_MUL)
				acc_q <= acc_nx;
			case (pc_q)
				6'd1:  ma_q <= sat_shr(abs128(acc_nx));
				6'd3:  mb_q <= sat_shr(abs128(acc_nx));
				6'd5:  mc_q <= sat_shr(abs128(acc_nx));
				6'd9:  s_q <= s_new;
				6'd12: begin
					nxy_q <= acc_nx[127];
					tmp_q <= sat_shr(abs128(acc_nx));
				end
				6'd16, 6'd20: tmp_q <= sat_shr(acc_nx);
				6'd13: jxy_q <= quo12;
				6'd17: jxx_q <= quo12;
				6'd21: jyy_q <= quo12;
				6'd22, 6'd24, 6'd26: cen_q <= quo3;
				6'd31: rcx_q <= wx_q[63] ? ((q > S31 + 64'd1) ? 32'h8000_0000 : 32'(~q + 64'd1))
				              : ((q > S31) ? 32'h7FFF_FFFF : q[31:0]);
				6'd32: rcy_q <= wy_q[63] ? ((q > S31 + 64'd1) ? 32'h8000_0000 : 32'(~q + 64'd1))
				              : ((q > S31) ? 32'h7FFF_FFFF : q[31:0]);
				6'd33: rcz_q <= wz_q[63] ? ((q > S31 + 64'd1) ? 32'h8000_0000 : 32'(~q + 64'd1))
				              : ((q > S31) ? 32'h7FFF_FFFF : q[31:0]);
				6'd34: rxx_q <= (q > M47) ? M47[46:0] : q[46:0];
				6'd35: ryy_q <= (q > M47) ? M47[46:0] : q[46:0];
				6'd36: rxy_q <= mxy_q[63]
				              ? ((q > M47 + 64'd1) ? 48'h8000_0000_0000 : 48'(~q + 64'd1))
				              : ((q > M47) ? M47[47:0] : q[47:0]);
				default: ;
			endcase
		end
		if (state_q == ST_OUT && out_free) begin
			degenerate   <= deg_q;
			polygon_area <= deg_q ? '0 : area_r;
			centroid_x   <= deg_q ? '0 : rcx_q;
			centroid_y   <= deg_q ? '0 : rcy_q;
			centroid_z   <= deg_q ? '0 : rcz_q;
			moment_xx    <= deg_q ? '0 : rxx_q;
			moment_yy    <= deg_q ? '0 : ryy_q;
			moment_xy    <= deg_q ? '0 : rxy_q;
		end
	end

	assign result_valid = ov_q;

	a_units_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(mul_done && iter_done))
		else $error("both shared units finished together");
	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ISSUE || state_q == ST_WAIT) |-> !vertex_ready)
		else $error("vertex taken during a sequence");
	a_degenerate_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && degenerate |-> polygon_area == '0 && moment_xx == '0)
		else $error("degenerate result carries data");
	a_final_needs_area: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ISSUE && pc_q >= PC_FIN_FIRST |-> area_q != '0)
		else $error("final division with zero area");

endmodule

[tb/sv/testbench.sv]
// testbench for polygon_area_centroid_inertia: streams polygons as vertex transfers
// and checks every result against a bit-exact predictor held in this file
// depends on pac_pkg and the polygon_area_centroid_inertia rtl
`timescale 1ns / 100ps

module testbench;

	localparam int FRAC       = 16;
	localparam int IDLE_LIMIT = 20000;
	localparam int N_RANDOM   = 1700;

	typedef struct packed {
		logic [47:0]        area;
		logic signed [31:0] cx;
		logic signed [31:0] cy;
		logic signed [31:0] cz;
		logic [46:0]        mxx;
		logic signed [47:0] mxy;
		logic [46:0]        myy;
		logic               degen;
	} polygon_result_t;

	logic               clk;
	logic               arst_n;
	logic               vertex_valid;
	logic               vertex_ready;
	logic signed [31:0] vertex_x;
	logic signed [31:0] vertex_y;
	logic signed [31:0] vertex_z;
	logic               last_vertex;
	logic               result_valid;
	logic               result_ready;
	logic [47:0]        polygon_area;
	logic signed [31:0] centroid_x;
	logic signed [31:0] centroid_y;
	logic signed [31:0] centroid_z;
	logic [46:0]        moment_xx;
	logic signed [47:0] moment_xy;
	logic [46:0]        moment_yy;
	logic               degenerate;

	polygon_area_centroid_inertia #(.FRACTION_BITS(FRAC)) uut (.*);

	// predictor state
	longint ax, ay, az, px, py, pz;
	int unsigned n_seen;
	bit [63:0] area_acc, mxx_acc, myy_acc;
	longint wx_acc, wy_acc, wz_acc, mxy_acc;

	polygon_result_t expected_results[$];
	int mismatches;
	int idle_cycles;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic bit [63:0] mag64(longint v);
		return v < 0 ? 64'd0 - 64'(v) : 64'(v);
	endfunction

	function automatic bit [127:0] smul(longint a, longint b);
		bit [127:0] r;
		r = {64'd0, mag64(a)} * {64'd0, mag64(b)};
		return ((a < 0) != (b < 0)) ? 128'd0 - r : r;
	endfunction

	function automatic bit [127:0] abs128(bit [127:0] a);
		return a[127] ? 128'd0 - a : a;
	endfunction

	function automatic bit [63:0] sat64(bit [127:0] a);
		return a[127:64] != 0 ? {64{1'b1}} : a[63:0];
	endfunction

	function automatic longint to_s64(bit neg, bit [63:0] m);
		if (!neg)
			return m[63] ? 64'h7FFF_FFFF_FFFF_FFFF : longint'(m);
		if (m[63])
			return 64'h8000_0000_0000_0000;
		return -longint'(m);
	endfunction

	function automatic longint sat_add(longint a, longint b);
		logic signed [64:0] r;
		r = 65'(a) + 65'(b);
		if (r > 65'sh0_7FFF_FFFF_FFFF_FFFF)
			return 64'h7FFF_FFFF_FFFF_FFFF;
		if (r < -65'sh0_8000_0000_0000_0000)
			return 64'h8000_0000_0000_0000;
		return longint'(r);
	endfunction

	function automatic bit [63:0] usat_add(bit [63:0] a, bit [63:0] b);
		bit [64:0] r;
		r = {1'b0, a} + {1'b0, b};
		return r[64] ? {64{1'b1}} : r[63:0];
	endfunction

	function automatic bit [63:0] cross_mag(longint a, longint b, longint c, longint d);
		return sat64(abs128(smul(a, b) - smul(c, d)) >> FRAC);
	endfunction

	function automatic bit [63:0] isqrt(bit [127:0] n);
		bit [63:0] r, t;
		r = 0;
		for (int b = 63; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if ({64'd0, t} * {64'd0, t} <= n)
				r = t;
		end
		return r;
	endfunction

	function automatic bit [63:0] quotient(bit [63:0] num, bit [63:0] den);
		return sat64(({64'd0, num} << FRAC) / {64'd0, den});
	endfunction

	function automatic bit [63:0] scaled_ratio(longint sum, bit [63:0] lim, bit [63:0] mask);
		bit [63:0] q;
		q = quotient(mag64(sum), area_acc);
		if (sum < 0) begin
			if (q > lim + 1)
				q = lim + 1;
			return (64'd0 - q) & mask;
		end
		return (q > lim ? lim : q) & mask;
	endfunction

	function automatic bit [63:0] square_moment(longint a, longint b, longint c);
		return sat64((smul(a, a) + smul(b, b) + smul(c, c)) >> FRAC) / 12;
	endfunction

	function automatic longint weigh(bit [63:0] s, longint v);
		return to_s64(v < 0, sat64(({64'd0, s} * {64'd0, mag64(v)}) >> FRAC));
	endfunction

	function automatic void add_triangle(longint cx, longint cy, longint cz);
		longint ux, uy, uz, vx, vy, vz, x12, x13, x23, y12, y13, y23;
		bit [63:0] ma, mb, mc, s, jxx, jyy, jxy;
		bit [127:0] pxy;
		ux = px - ax; uy = py - ay; uz = pz - az;
		vx = cx - ax; vy = cy - ay; vz = cz - az;
		ma = cross_mag(uy, vz, uz, vy);
		mb = cross_mag(uz, vx, ux, vz);
		mc = cross_mag(ux, vy, uy, vx);
		s = isqrt({64'd0, ma} * {64'd0, ma} + {64'd0, mb} * {64'd0, mb}
			+ {64'd0, mc} * {64'd0, mc}) >> 1;
		x12 = ax + px; x13 = ax + cx; x23 = px + cx;
		y12 = ay + py; y13 = ay + cy; y23 = py + cy;
		pxy = smul(x12, y12) + smul(x13, y13) + smul(x23, y23);
		jxy = sat64(abs128(pxy) >> FRAC) / 12;
		jxx = square_moment(x12, x13, x23);
		jyy = square_moment(y12, y13, y23);
		area_acc = usat_add(area_acc, s);
		wx_acc = sat_add(wx_acc, weigh(s, (ax + px + cx) / 3));
		wy_acc = sat_add(wy_acc, weigh(s, (ay + py + cy) / 3));
		wz_acc = sat_add(wz_acc, weigh(s, (az + pz + cz) / 3));
		mxx_acc = usat_add(mxx_acc, sat64(({64'd0, s} * {64'd0, jxx}) >> FRAC));
		myy_acc = usat_add(myy_acc, sat64(({64'd0, s} * {64'd0, jyy}) >> FRAC));
		mxy_acc = sat_add(mxy_acc,
			to_s64(pxy[127], sat64(({64'd0, s} * {64'd0, jxy}) >> FRAC)));
	endfunction

	function automatic void clear_polygon();
		ax = 0; ay = 0; az = 0; px = 0; py = 0; pz = 0;
		n_seen = 0;
		area_acc = 0; mxx_acc = 0; myy_acc = 0;
		wx_acc = 0; wy_acc = 0; wz_acc = 0; mxy_acc = 0;
	endfunction

	function automatic void predict_vertex(int x, int y, int z, bit last);
		polygon_result_t r;
		bit [63:0] q;
		if (n_seen == 0) begin
			ax = x; ay = y; az = z;
		end else if (n_seen >= 2) begin
			add_triangle(x, y, z);
		end
		px = x; py = y; pz = z;
		if (n_seen < 3)
			n_seen++;
		if (!last)
			return;
		r = '0;
		if (n_seen < 3 || area_acc == 0) begin
			r.degen = 1'b1;
		end else begin
			r.area = area_acc > 64'hFFFF_FFFF_FFFF ? 48'hFFFF_FFFF_FFFF : area_acc[47:0];
			r.cx = 32'(scaled_ratio(wx_acc, 64'h7FFF_FFFF, 64'hFFFF_FFFF));
			r.cy = 32'(scaled_ratio(wy_acc, 64'h7FFF_FFFF, 64'hFFFF_FFFF));
			r.cz = 32'(scaled_ratio(wz_acc, 64'h7FFF_FFFF, 64'hFFFF_FFFF));
			q = quotient(mxx_acc, area_acc);
			r.mxx = q > 64'h7FFF_FFFF_FFFF ? {47{1'b1}} : q[46:0];
			r.mxy = 48'(scaled_ratio(mxy_acc, 64'h7FFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF));
			q = quotient(myy_acc, area_acc);
			r.myy = q > 64'h7FFF_FFFF_FFFF ? {47{1'b1}} : q[46:0];
		end
		expected_results.push_back(r);
		clear_polygon();
	endfunction

	function automatic int pick_gap();
		int k;
		k = $urandom_range(0, 99);
		if (k < 55)
			return 0;
		if (k < 95)
			return $urandom_range(1, 4);
		return $urandom_range(20, 300);
	endfunction

	task automatic send_vertex(int x, int y, int z, bit last);
		int gap;
		vertex_valid <= 1'b1;
		vertex_x <= x;
		vertex_y <= y;
		vertex_z <= z;
		last_vertex <= last;
		do
			@(posedge clk);
		while (!vertex_ready);
		predict_vertex(x, y, z, last);
		gap = pick_gap();
		if (gap > 0) begin
			vertex_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic int rand_coord(int scale);
		if (scale >= 31)
			return int'($urandom);
		return int'($urandom_range(0, 2 << scale)) - (1 << scale);
	endfunction

	task automatic send_polygon(int n, int scale);
		for (int i = 0; i < n; i++)
			send_vertex(rand_coord(scale), rand_coord(scale), rand_coord(scale), i == n - 1);
	endtask

	// fewer than three vertices, collinear points, repeated points
	task automatic test_degenerate();
		send_vertex(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000, 1'b1);
		send_vertex(32'sh0001_0000, 32'sh0000_0000, 32'sh0000_0000, 1'b0);
		send_vertex(32'sh0000_0000, 32'sh0001_0000, 32'sh0000_0000, 1'b1);
		send_vertex(0, 0, 0, 1'b0);
		send_vertex(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, 1'b0);
		send_vertex(32'sh0002_0000, 32'sh0002_0000, 32'sh0002_0000, 1'b1);
		send_vertex(32'sh0005_0000, -32'sh0003_0000, 0, 1'b0);
		send_vertex(32'sh0005_0000, -32'sh0003_0000, 0, 1'b0);
		send_vertex(32'sh0005_0000, -32'sh0003_0000, 0, 1'b1);
	endtask

	// small well-formed triangles and a square in several planes
	task automatic test_shapes();
		send_vertex(0, 0, 0, 1'b0);
		send_vertex(32'sh0004_0000, 0, 0, 1'b0);
		send_vertex(0, 32'sh0003_0000, 0, 1'b1);
		send_vertex(-32'sh0002_0000, -32'sh0002_0000, 32'sh0001_0000, 1'b0);
		send_vertex(32'sh0002_0000, -32'sh0002_0000, 32'sh0001_0000, 1'b0);
		send_vertex(32'sh0002_0000, 32'sh0002_0000, 32'sh0001_0000, 1'b0);
		send_vertex(-32'sh0002_0000, 32'sh0002_0000, 32'sh0001_0000, 1'b1);
		send_vertex(32'sh0000_8000, 0, 0, 1'b0);
		send_vertex(0, 0, 32'sh0000_8000, 1'b0);
		send_vertex(0, 32'sh0000_0001, 0, 1'b1);
	endtask

	// extreme coordinates at the limits of the signed 32-bit range, to exercise saturation
	task automatic test_extremes();
		send_vertex(32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0);
		send_vertex(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 1'b0);
		send_vertex(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0);
		send_vertex(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b1);
		send_vertex(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0);
		send_vertex(32'sh7FFF_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0);
		send_vertex(32'sh7FFF_FFFF, 32'sh7FFF_0000, 32'sh7FFF_FFFF, 1'b1);
	endtask

	task automatic test_random_polygons();
		int sent, n, scale, k;
		sent = 0;
		while (sent < N_RANDOM) begin
			k = $urandom_range(0, 99);
			n = k < 5 ? $urandom_range(1, 2) : (k < 90 ? $urandom_range(3, 6)
				: $urandom_range(7, 16));
			k = $urandom_range(0, 99);
			scale = k < 70 ? $urandom_range(8, 22) : (k < 85 ? $urandom_range(23, 30) : 31);
			if ($urandom_range(0, 19) == 0) begin
				// collinear polygon, zero area
				for (int i = 0; i < n; i++)
					send_vertex(i << 12, i << 13, -(i << 11), i == n - 1);
			end else begin
				send_polygon(n, scale);
			end
			sent += n;
		end
	endtask

	// result channel stall pattern
	int stall_left;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			result_ready <= 1'b0;
		end else if ($urandom_range(0, 3) == 0) begin
			stall_left <= pick_gap();
			result_ready <= 1'b0;
		end else begin
			result_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		polygon_result_t got, want;
		if (arst_n && result_valid && result_ready) begin
			got = '{polygon_area, centroid_x, centroid_y, centroid_z,
				moment_xx, moment_xy, moment_yy, degenerate};
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result transfer: %p", got);
			end else begin
				want = expected_results.pop_front();
				if (got.area !== want.area || got.cx !== want.cx || got.cy !== want.cy
					|| got.cz !== want.cz || got.mxx !== want.mxx || got.mxy !== want.mxy
					|| got.myy !== want.myy || got.degen !== want.degen) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result mismatch\n  expected %p\n  actual   %p", want, got);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((vertex_valid && vertex_ready) || (result_valid && result_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("testbench NOT OK");
			$finish;
		end
	end

	initial begin
		int wait_cycles;
		mismatches = 0;
		idle_cycles = 0;
		clear_polygon();
		arst_n = 1'b0;
		vertex_valid = 1'b0;
		vertex_x = 0;
		vertex_y = 0;
		vertex_z = 0;
		last_vertex = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_degenerate();
		test_shapes();
		test_extremes();
		test_random_polygons();
		vertex_valid <= 1'b0;
		wait_cycles = 0;
		while (expected_results.size() != 0 && wait_cycles < 200000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (1000) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule

[sim.f]
rtl/core/pac_pkg.sv
rtl/core/pac_mul.sv
rtl/core/pac_iter.sv
rtl/core/polygon_area_centroid_inertia.sv
tb/sv/testbench.sv
